// File: design/acs_pkg.sv
// Package with shared types, constants and codes of the ADC channel calibrate and scale block.
package acs_pkg;

  // Default values of the top-level parameters.
  localparam int CHANNELS_DEF      = 16;
  localparam int FRACTION_BITS_DEF = 32;

  // Fixed field widths.
  localparam int RAW_W     = 32;
  localparam int COEF_W    = 48;
  localparam int VAL_W     = 64;
  localparam int BUF_W     = 32;
  localparam int TOTAL_W   = 48;
  localparam int CC_W      = 5;
  localparam int CH_OUT_W  = 4;
  localparam int KIND_W    = 2;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;

  // Exact product of a coefficient and a 64-bit value.
  localparam int ACC_W = COEF_W + VAL_W;

  // Partial-product split of the shared multiplier: two halves of each operand.
  localparam int A_SPLIT   = COEF_W / 2;
  localparam int B_SPLIT   = VAL_W / 2;
  localparam int A_PART_W  = (COEF_W - A_SPLIT) + 1;
  localparam int B_PART_W  = (VAL_W - B_SPLIT) + 1;
  localparam int PP_W      = A_PART_W + B_PART_W;
  localparam int MUL_STEPS = 4;
  localparam int STEP_W    = 3;
  localparam int SEL_W     = 2;
  localparam int SHIFT_W   = $clog2(ACC_W);

  typedef enum logic [0:0] {
    OP_PROCESS = 1'b0,
    OP_LOAD    = 1'b1
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_CAL_SLOPE    = 2'd0,
    KIND_CAL_OFFSET   = 2'd1,
    KIND_SCALE_SLOPE  = 2'd2,
    KIND_SCALE_OFFSET = 2'd3
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAMPLE_IS_32BIT = 3'd0,
    CFG_RAW_PASSTHROUGH = 3'd1,
    CFG_CHANNEL_COUNT   = 3'd2,
    CFG_BUFFER_LENGTH   = 3'd3,
    CFG_RECYCLE_MODE    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CAL_MUL,
    ST_CAL_FIN,
    ST_SCALE_MUL,
    ST_SCALE_FIN
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic             accept;     // input transfer may take place this cycle
    logic             mul_scale;  // multiplier operands: 1 scale stage, 0 calibration stage
    logic             mul_pp;     // form one partial product
    logic [SEL_W-1:0] mul_sel;    // which operand halves form it
    logic             mul_acc;    // add the registered partial product
    logic             cal_fin;    // finish calibration stage into the count register
    logic             scale_fin;  // finish scale stage into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic passthrough;
    logic out_free;
  } status_t;

endpackage

// File: design/acs_ctrl.sv
// Controller state machine that sequences the two multiply-add stages of one sample.
module acs_ctrl
  import acs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    operation_i,
  input  status_t status_i,
  output logic    in_stall_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic mul_last;

  assign mul_last = (step_q == STEP_W'(MUL_STEPS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // Next state and step counter.
  always_comb begin
    state_d = state_q;
    step_d  = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && (operation_i == OP_PROCESS)) begin
          state_d = status_i.passthrough ? ST_CAL_FIN : ST_CAL_MUL;
        end
      end
      ST_CAL_MUL: begin
        if (mul_last) begin
          state_d = ST_CAL_FIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_CAL_FIN: begin
        state_d = ST_SCALE_MUL;
      end
      ST_SCALE_MUL: begin
        if (mul_last) begin
          state_d = ST_SCALE_FIN;
        end else begin
          step_d = step_q + STEP_W'(1);
        end
      end
      ST_SCALE_FIN: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
      end
      ST_CAL_MUL, ST_SCALE_MUL: begin
        cmd_o.mul_scale = (state_q == ST_SCALE_MUL);
        cmd_o.mul_pp    = !mul_last;
        cmd_o.mul_sel   = step_q[SEL_W-1:0];
        cmd_o.mul_acc   = (step_q != '0);
      end
      ST_CAL_FIN: begin
        cmd_o.cal_fin = 1'b1;
      end
      ST_SCALE_FIN: begin
        cmd_o.scale_fin = status_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

// File: design/acs_datapath.sv
// Datapath: configuration, coefficient memories, scan counters, shared multiplier and output register.
module acs_datapath
  import acs_pkg::*;
#(
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  cmd_t                       cmd_i,
  input  logic                       operation_i,
  input  logic [RAW_W-1:0]           raw_sample_i,
  input  logic [CH_OUT_W-1:0]        coef_channel_i,
  input  logic [KIND_W-1:0]          coef_kind_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  input  logic                       out_stall_i,
  output status_t                    status_o,
  output logic                       out_valid_o,
  output logic signed [VAL_W-1:0]    scaled_value_o,
  output logic [CH_OUT_W-1:0]        sample_channel_o,
  output logic [BUF_W-1:0]           buffer_position_o,
  output logic                       buffer_wrapped_o,
  output logic                       all_done_o,
  output logic [TOTAL_W-1:0]         samples_so_far_o
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  function automatic logic [VAL_W-1:0] sat64(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-VAL_W:0] top;
    top = x[ACC_W-1:VAL_W-1];
    if ((&top) || !(|top)) begin
      return x[VAL_W-1:0];
    end
    return x[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
  endfunction

  // Configuration registers.
  logic              sample_32_q, passthrough_q, recycle_q;
  logic [CC_W-1:0]   chan_count_q;
  logic [BUF_W-1:0]  buf_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_32_q   <= 1'b0;
      passthrough_q <= 1'b0;
      chan_count_q  <= CC_W'(1);
      buf_len_q     <= BUF_W'(1);
      recycle_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_IS_32BIT: sample_32_q   <= cfg_data_i[0];
        CFG_RAW_PASSTHROUGH: passthrough_q <= cfg_data_i[0];
        CFG_CHANNEL_COUNT:   chan_count_q  <= cfg_data_i[CC_W-1:0];
        CFG_BUFFER_LENGTH:   buf_len_q     <= cfg_data_i[BUF_W-1:0];
        CFG_RECYCLE_MODE:    recycle_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  logic proc_take, load_take;
  assign proc_take = cmd_i.accept && (operation_i == OP_PROCESS);
  assign load_take = cmd_i.accept && (operation_i == OP_LOAD);

  // Coefficient memories, one per kind.
  logic [COEF_W-1:0] cal_slope_mem   [CHANNELS];
  logic [COEF_W-1:0] cal_off_mem     [CHANNELS];
  logic [COEF_W-1:0] scale_slope_mem [CHANNELS];
  logic [COEF_W-1:0] scale_off_mem   [CHANNELS];

  logic [31:0]     coef_ch_wide;
  logic [CH_W-1:0] wr_addr;
  logic            wr_ok;
  assign coef_ch_wide = 32'(coef_channel_i);
  assign wr_addr      = coef_ch_wide[CH_W-1:0];
  assign wr_ok        = load_take && (coef_ch_wide < 32'(CHANNELS));

  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      unique case (coef_kind_i)
        KIND_CAL_SLOPE:    cal_slope_mem[wr_addr]   <= coef_value_i;
        KIND_CAL_OFFSET:   cal_off_mem[wr_addr]     <= coef_value_i;
        KIND_SCALE_SLOPE:  scale_slope_mem[wr_addr] <= coef_value_i;
        KIND_SCALE_OFFSET: scale_off_mem[wr_addr]   <= coef_value_i;
        default: ;
      endcase
    end
  end

  // Scan state.
  logic [CH_W-1:0]    chan_q;
  logic [BUF_W-1:0]   buf_q;
  logic [TOTAL_W-1:0] total_q;

  logic [31:0]      ch_limit, ch_wide, ch_plus;
  logic [CH_W-1:0]  chan_next;
  logic [BUF_W:0]   buf_plus, buf_limit;
  logic             wrapped;
  logic [TOTAL_W-1:0] total_next;

  always_comb begin
    if (chan_count_q == '0) begin
      ch_limit = 32'd1;
    end else if (32'(chan_count_q) > 32'(CHANNELS)) begin
      ch_limit = 32'(CHANNELS);
    end else begin
      ch_limit = 32'(chan_count_q);
    end
    ch_wide   = 32'(chan_q);
    ch_plus   = ch_wide + 32'd1;
    chan_next = (ch_plus >= ch_limit) ? '0 : ch_plus[CH_W-1:0];
    buf_plus  = {1'b0, buf_q} + (BUF_W + 1)'(1);
    buf_limit = (buf_len_q == '0) ? (BUF_W + 1)'(1) : {1'b0, buf_len_q};
    wrapped   = (buf_plus >= buf_limit);
    total_next = total_q + TOTAL_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q  <= '0;
      buf_q   <= '0;
      total_q <= '0;
    end else if (proc_take) begin
      chan_q  <= chan_next;
      buf_q   <= wrapped ? '0 : buf_plus[BUF_W-1:0];
      total_q <= total_next;
    end
  end

  // Item registers captured at the input transfer.
  logic [RAW_W-1:0]         raw_q;
  logic signed [COEF_W-1:0] cal_slope_q, cal_off_q, scale_slope_q, scale_off_q;
  logic [CH_OUT_W-1:0]      item_ch_q;
  logic [BUF_W-1:0]         item_buf_q;
  logic                     item_wrap_q, item_done_q;
  logic [TOTAL_W-1:0]       item_total_q;

  always_ff @(posedge clk_i) begin
    if (proc_take) begin
      raw_q         <= sample_32_q ? raw_sample_i : RAW_W'(raw_sample_i[15:0]);
      cal_slope_q   <= cal_slope_mem[chan_q];
      cal_off_q     <= cal_off_mem[chan_q];
      scale_slope_q <= scale_slope_mem[chan_q];
      scale_off_q   <= scale_off_mem[chan_q];
      item_ch_q     <= ch_wide[CH_OUT_W-1:0];
      item_buf_q    <= buf_q;
      item_wrap_q   <= wrapped;
      item_done_q   <= wrapped && !recycle_q;
      item_total_q  <= total_next;
    end
  end

  // Shared multiplier: one partial product per cycle, accumulated in the next cycle.
  logic signed [COEF_W-1:0]   a_op;
  logic signed [VAL_W-1:0]    b_op;
  logic signed [A_PART_W-1:0] a_part;
  logic signed [B_PART_W-1:0] b_part;
  logic signed [PP_W-1:0]     pp_q;
  logic [SEL_W-1:0]           pp_sel_q;
  logic [SHIFT_W-1:0]         pp_shift;
  logic signed [ACC_W-1:0]    acc_q, pp_ext;
  logic signed [VAL_W-1:0]    count_q;

  always_comb begin
    a_op = cmd_i.mul_scale ? scale_slope_q : cal_slope_q;
    b_op = cmd_i.mul_scale ? count_q : VAL_W'(raw_q);
    if (cmd_i.mul_sel[0]) begin
      a_part = A_PART_W'(signed'(a_op[COEF_W-1:A_SPLIT]));
    end else begin
      a_part = signed'({1'b0, a_op[A_SPLIT-1:0]});
    end
    if (cmd_i.mul_sel[1]) begin
      b_part = B_PART_W'(signed'(b_op[VAL_W-1:B_SPLIT]));
    end else begin
      b_part = signed'({1'b0, b_op[B_SPLIT-1:0]});
    end
    pp_shift = (pp_sel_q[0] ? SHIFT_W'(A_SPLIT) : SHIFT_W'(0))
             + (pp_sel_q[1] ? SHIFT_W'(B_SPLIT) : SHIFT_W'(0));
    pp_ext   = ACC_W'(pp_q) <<< pp_shift;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_pp) begin
      pp_q     <= a_part * b_part;
      pp_sel_q <= cmd_i.mul_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_take || cmd_i.cal_fin) begin
      acc_q <= '0;
    end else if (cmd_i.mul_acc) begin
      acc_q <= acc_q + pp_ext;
    end
  end

  // Calibration stage result, or the raw count moved to the fixed-point grid.
  logic signed [ACC_W-1:0] cal_sum;
  assign cal_sum = passthrough_q ? (ACC_W'(raw_q) <<< FRACTION_BITS)
                                 : (acc_q + ACC_W'(cal_off_q));

  always_ff @(posedge clk_i) begin
    if (cmd_i.cal_fin) begin
      count_q <= sat64(cal_sum);
    end
  end

  // Scale stage: floor shift back to the value grid, then add the offset.
  logic signed [ACC_W-1:0] scale_sum;
  assign scale_sum = (acc_q >>> FRACTION_BITS) + ACC_W'(scale_off_q);

  // Output register.
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.scale_fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_fin) begin
      scaled_value_o    <= sat64(scale_sum);
      sample_channel_o  <= item_ch_q;
      buffer_position_o <= item_buf_q;
      buffer_wrapped_o  <= item_wrap_q;
      all_done_o        <= item_done_q;
      samples_so_far_o  <= item_total_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o.passthrough = passthrough_q;
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

endmodule

// File: design/adc_channel_calibrate_scale_top.sv
// Top level of the per-channel ADC calibrate and scale block.
//
// Input channel: in_valid_i / in_stall_o with one operation per transfer. A load
// operation writes one coefficient (calibration or scale slope or offset) of one
// channel and does not stall the input. A process operation takes a raw count,
// applies the current scan channel's calibration and scale coefficients and
// produces one result on the output channel out_valid_o / out_stall_i.
// A processed sample keeps the input stalled until the block is done with it: the
// one shared partial-product multiplier runs the calibration and then the scale
// multiply, each followed by a finishing step. With raw passthrough set the
// calibration multiply is skipped. The result turns valid on the output channel
// once the scale stage's finishing step has written the output register.
// The output register holds a finished result while the receiver stalls; the block
// keeps taking loads and works on the next sample meanwhile, and only waits in its
// last stage until the register is free.
// Reset clears the scan channel, buffer index and sample count and sets the
// configuration registers to their defaults. Coefficient memories are not cleared
// and must be loaded before the channels that use them are processed.
// Configuration writes go through cfg_we_i, cfg_index_i and cfg_data_i; the user
// must make them only while idle, as the block itself does not enforce this.
module adc_channel_calibrate_scale_top
  import acs_pkg::*;
#(
  parameter int CHANNELS      = CHANNELS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [CFG_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       operation_i,
  input  logic [RAW_W-1:0]           raw_sample_i,
  input  logic [CH_OUT_W-1:0]        coef_channel_i,
  input  logic [KIND_W-1:0]          coef_kind_i,
  input  logic signed [COEF_W-1:0]   coef_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [VAL_W-1:0]    scaled_value_o,
  output logic [CH_OUT_W-1:0]        sample_channel_o,
  output logic [BUF_W-1:0]           buffer_position_o,
  output logic                       buffer_wrapped_o,
  output logic                       all_done_o,
  output logic [TOTAL_W-1:0]         samples_so_far_o
);

  cmd_t    cmd;
  status_t status;

  // The controller only sequences; arithmetic and data state live in the datapath.
  acs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .operation_i (operation_i),
    .status_i    (status),
    .in_stall_o  (in_stall_o),
    .cmd_o       (cmd)
  );

  acs_datapath #(
    .CHANNELS      (CHANNELS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .operation_i       (operation_i),
    .raw_sample_i      (raw_sample_i),
    .coef_channel_i    (coef_channel_i),
    .coef_kind_i       (coef_kind_i),
    .coef_value_i      (coef_value_i),
    .out_stall_i       (out_stall_i),
    .status_o          (status),
    .out_valid_o       (out_valid_o),
    .scaled_value_o    (scaled_value_o),
    .sample_channel_o  (sample_channel_o),
    .buffer_position_o (buffer_position_o),
    .buffer_wrapped_o  (buffer_wrapped_o),
    .all_done_o        (all_done_o),
    .samples_so_far_o  (samples_so_far_o)
  );

  // A processed sample keeps the input stalled while its stages run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (operation_i == OP_PROCESS)) |=> in_stall_o)
    else $error("input not stalled after a sample transfer");

  // A coefficient load finishes in its own cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (operation_i == OP_LOAD)) |=> !in_stall_o)
    else $error("input stalled after a coefficient load");

  // Completion is only flagged on the sample that fills the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && all_done_o) |-> buffer_wrapped_o)
    else $error("all_done without buffer_wrapped");

  // No new result can appear within the cycle after a sample transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (operation_i == OP_PROCESS) && !out_valid_o)
      |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

// File: sim/adc_channel_calibrate_scale_top_tb.sv
// Self-checking testbench of the ADC channel calibrate and scale block.
module adc_channel_calibrate_scale_top_tb;
  import acs_pkg::*;

  localparam int NUM_CH = CHANNELS_DEF;
  localparam int FRAC = FRACTION_BITS_DEF;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 175;
  localparam int SETTLE_CYCLES = 20;
  localparam logic signed [COEF_W-1:0] COEF_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [COEF_W-1:0] COEF_MIN = 48'sh8000_0000_0000;
  localparam logic signed [COEF_W-1:0] UNITY = 48'sh0001_0000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [CH_OUT_W-1:0] channel;
    logic [BUF_W-1:0] position;
    logic wrapped;
    logic done;
    logic [TOTAL_W-1:0] count;
  } sample_result_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic operation_i = 1'b0;
  logic [RAW_W-1:0] raw_sample_i = '0;
  logic [CH_OUT_W-1:0] coef_channel_i = '0;
  logic [KIND_W-1:0] coef_kind_i = '0;
  logic signed [COEF_W-1:0] coef_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [VAL_W-1:0] scaled_value_o;
  logic [CH_OUT_W-1:0] sample_channel_o;
  logic [BUF_W-1:0] buffer_position_o;
  logic buffer_wrapped_o;
  logic all_done_o;
  logic [TOTAL_W-1:0] samples_so_far_o;

  // Shadow copy of the block's configuration, scan state and coefficient memories.
  logic cfg_wide_sample;
  logic cfg_passthrough;
  logic [CC_W-1:0] cfg_chan_count;
  logic [BUF_W-1:0] cfg_buf_len;
  logic cfg_recycle;
  logic [CH_OUT_W-1:0] scan_ch;
  logic [BUF_W-1:0] buf_idx;
  logic [TOTAL_W-1:0] sample_total;
  logic signed [COEF_W-1:0] cal_slope_mem [NUM_CH];
  logic signed [COEF_W-1:0] cal_offset_mem [NUM_CH];
  logic signed [COEF_W-1:0] scale_slope_mem [NUM_CH];
  logic signed [COEF_W-1:0] scale_offset_mem [NUM_CH];

  sample_result_t pending_results [$];
  int mismatch_count = 0;
  bit calm = 1'b0;

  adc_channel_calibrate_scale_top i_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .operation_i       (operation_i),
    .raw_sample_i      (raw_sample_i),
    .coef_channel_i    (coef_channel_i),
    .coef_kind_i       (coef_kind_i),
    .coef_value_i      (coef_value_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .scaled_value_o    (scaled_value_o),
    .sample_channel_o  (sample_channel_o),
    .buffer_position_o (buffer_position_o),
    .buffer_wrapped_o  (buffer_wrapped_o),
    .all_done_o        (all_done_o),
    .samples_so_far_o  (samples_so_far_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic signed [VAL_W-1:0] clamp64(logic signed [127:0] v);
    if (v[127:VAL_W-1] == {(128-VAL_W+1){v[VAL_W-1]}}) return v[VAL_W-1:0];
    return v[127] ? VAL_MIN : VAL_MAX;
  endfunction

  // Computes the result of one process transfer and advances the scan state.
  function automatic sample_result_t predict_scaled_sample(logic [RAW_W-1:0] raw_in);
    sample_result_t r;
    int ch_lim;
    logic [BUF_W:0] buf_lim;
    logic [BUF_W:0] next_buf;
    logic [RAW_W-1:0] raw;
    logic signed [127:0] raw_ext;
    logic signed [127:0] slope;
    logic signed [127:0] offset;
    logic signed [127:0] acc;
    logic signed [VAL_W-1:0] level;
    logic signed [127:0] level_ext;
    ch_lim = (cfg_chan_count == '0) ? 1 :
             ((int'(cfg_chan_count) > NUM_CH) ? NUM_CH : int'(cfg_chan_count));
    buf_lim = (cfg_buf_len == '0) ? (BUF_W + 1)'(1) : {1'b0, cfg_buf_len};
    raw = cfg_wide_sample ? raw_in : {16'b0, raw_in[15:0]};
    raw_ext = $signed({96'b0, raw});
    if (cfg_passthrough) begin
      acc = raw_ext <<< FRAC;
    end else begin
      slope = cal_slope_mem[scan_ch];
      offset = cal_offset_mem[scan_ch];
      acc = slope * raw_ext + offset;
    end
    level = clamp64(acc);
    level_ext = level;
    slope = scale_slope_mem[scan_ch];
    offset = scale_offset_mem[scan_ch];
    acc = ((slope * level_ext) >>> FRAC) + offset;
    sample_total = sample_total + TOTAL_W'(1);
    r.value = clamp64(acc);
    r.channel = scan_ch;
    r.position = buf_idx;
    next_buf = {1'b0, buf_idx} + (BUF_W + 1)'(1);
    r.wrapped = (next_buf >= buf_lim);
    r.done = r.wrapped && !cfg_recycle;
    r.count = sample_total;
    buf_idx = r.wrapped ? '0 : next_buf[BUF_W-1:0];
    scan_ch = (int'(scan_ch) + 1 >= ch_lim) ? '0 : scan_ch + CH_OUT_W'(1);
    return r;
  endfunction

  function automatic logic signed [COEF_W-1:0] pick_coef(kind_e kind);
    int unsigned sel;
    logic [31:0] r;
    logic signed [COEF_W-1:0] v;
    sel = $urandom_range(99);
    r = $urandom;
    if (sel < 5) begin
      v = COEF_MAX;
    end else if (sel < 10) begin
      v = COEF_MIN;
    end else if (sel < 25) begin
      v = {r[15:0], 32'($urandom)};
    end else if (kind == KIND_CAL_SLOPE || kind == KIND_SCALE_SLOPE) begin
      // Gain near one, now and then inverted.
      v = UNITY + ($signed({{16{r[31]}}, r}) >>> 4);
      if (sel > 90) v = -v;
    end else begin
      v = $signed({{16{r[31]}}, r}) <<< $urandom_range(0, 12);
    end
    return v;
  endfunction

  function automatic logic [RAW_W-1:0] pick_raw();
    case ($urandom_range(19))
      0: return '0;
      1: return '1;
      2: return 32'h0000_FFFF;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Output side: the receiver stalls about 30 percent of the cycles outside the calm phase.
  always @(negedge clk_i) begin
    out_stall_i <= calm ? 1'b0 : ($urandom_range(99) < 30);
  end

  always @(posedge clk_i) begin : check_results
    sample_result_t got;
    sample_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {scaled_value_o, sample_channel_o, buffer_position_o, buffer_wrapped_o,
             all_done_o, samples_so_far_o};
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: value %h channel %0d position %0d", got.value,
                   got.channel, got.position);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch, expected: value %h ch %0d pos %0d wrap %b done %b count %0d",
                     want.value, want.channel, want.position, want.wrapped, want.done,
                     want.count);
            $display("mismatch, actual:   value %h ch %0d pos %0d wrap %b done %b count %0d",
                     got.value, got.channel, got.position, got.wrapped, got.done, got.count);
          end
        end
      end
    end
  end

  // Sends one item and holds it until the transfer takes place. Valid is left high so
  // that a following item can go out back to back.
  task automatic send_item(op_e op, logic [RAW_W-1:0] raw, logic [CH_OUT_W-1:0] chan,
                           kind_e kind, logic signed [COEF_W-1:0] val);
    int gap;
    sample_result_t expected;
    if (!calm && $urandom_range(99) < 30) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    operation_i <= op;
    raw_sample_i <= raw;
    coef_channel_i <= chan;
    coef_kind_i <= kind;
    coef_value_i <= val;
    do @(posedge clk_i); while (in_stall_o);
    if (op == OP_LOAD) begin
      case (kind)
        KIND_CAL_SLOPE: cal_slope_mem[chan] = val;
        KIND_CAL_OFFSET: cal_offset_mem[chan] = val;
        KIND_SCALE_SLOPE: scale_slope_mem[chan] = val;
        default: scale_offset_mem[chan] = val;
      endcase
    end else begin
      expected = predict_scaled_sample(raw);
      pending_results = {pending_results, expected};
    end
  endtask

  task automatic load_coef(logic [CH_OUT_W-1:0] chan, kind_e kind,
                           logic signed [COEF_W-1:0] val);
    send_item(OP_LOAD, $urandom, chan, kind, val);
  endtask

  task automatic process_raw(logic [RAW_W-1:0] raw);
    send_item(OP_PROCESS, raw, CH_OUT_W'($urandom), kind_e'($urandom_range(3)),
              COEF_W'({$urandom, $urandom}));
  endtask

  // Lowers valid and waits until every expected result has arrived and the block
  // has had time to settle.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CFG_W-1:0] data);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SAMPLE_IS_32BIT: cfg_wide_sample = data[0];
      CFG_RAW_PASSTHROUGH: cfg_passthrough = data[0];
      CFG_CHANNEL_COUNT: cfg_chan_count = data[CC_W-1:0];
      CFG_BUFFER_LENGTH: cfg_buf_len = data;
      CFG_RECYCLE_MODE: cfg_recycle = data[0];
      default: ;
    endcase
  endtask

  // Writes one register with random bits above its width.
  task automatic cfg_write_noisy(cfg_idx_e idx, logic [CFG_W-1:0] val);
    logic [CFG_W-1:0] data;
    data = $urandom;
    case (idx)
      CFG_CHANNEL_COUNT: data[CC_W-1:0] = val[CC_W-1:0];
      CFG_BUFFER_LENGTH: data = val;
      default: data[0] = val[0];
    endcase
    cfg_write(idx, data);
  endtask

  // Every coefficient of every channel is written before any sample reads it.
  task automatic test_coefficient_loads();
    for (int ch = 0; ch < NUM_CH; ch++) begin
      for (int k = 0; k < 4; k++) begin
        load_coef(CH_OUT_W'(ch), kind_e'(k), pick_coef(kind_e'(k)));
      end
    end
  endtask

  // Raw and coefficient extremes on channel 0 with the reset scan settings, so that
  // every sample fills the one-slot buffer and raises completion.
  task automatic test_field_extremes();
    load_coef(0, KIND_CAL_SLOPE, UNITY);
    load_coef(0, KIND_CAL_OFFSET, '0);
    load_coef(0, KIND_SCALE_SLOPE, UNITY);
    load_coef(0, KIND_SCALE_OFFSET, '0);
    process_raw('0);
    process_raw('1);
    cfg_write(CFG_SAMPLE_IS_32BIT, 32'd1);
    process_raw('1);
    process_raw(32'h8000_0000);
    load_coef(0, KIND_CAL_SLOPE, COEF_MAX);
    process_raw('1);
    load_coef(0, KIND_CAL_SLOPE, COEF_MIN);
    load_coef(0, KIND_CAL_OFFSET, COEF_MIN);
    process_raw('1);
    load_coef(0, KIND_SCALE_SLOPE, COEF_MAX);
    load_coef(0, KIND_SCALE_OFFSET, COEF_MAX);
    process_raw(32'h0000_1234);
    // Passthrough of a count that no longer fits the signed range saturates.
    cfg_write(CFG_RAW_PASSTHROUGH, 32'd1);
    load_coef(0, KIND_SCALE_SLOPE, UNITY);
    load_coef(0, KIND_SCALE_OFFSET, COEF_MIN);
    process_raw('1);
    process_raw(32'h7FFF_FFFF);
    cfg_write(CFG_RAW_PASSTHROUGH, 32'd0);
  endtask

  // Clamping of channel count and buffer length, and indexes past a shrunken limit.
  task automatic test_count_limits();
    cfg_write(CFG_CHANNEL_COUNT, 32'd16);
    cfg_write(CFG_BUFFER_LENGTH, 32'd100);
    while (scan_ch < 5 || buf_idx < 3) process_raw(pick_raw());
    cfg_write(CFG_CHANNEL_COUNT, 32'd3);
    cfg_write(CFG_BUFFER_LENGTH, 32'd2);
    process_raw(pick_raw());
    process_raw(pick_raw());
    cfg_write(CFG_CHANNEL_COUNT, 32'd0);
    cfg_write(CFG_BUFFER_LENGTH, 32'd0);
    process_raw(pick_raw());
    process_raw(pick_raw());
    cfg_write(CFG_CHANNEL_COUNT, 32'd31);
    process_raw(pick_raw());
    process_raw(pick_raw());
  endtask

  // Completion with the channel still wrapping, then continuous wrap.
  task automatic test_completion_wrap();
    cfg_write(CFG_CHANNEL_COUNT, 32'd3);
    cfg_write(CFG_BUFFER_LENGTH, 32'd4);
    cfg_write(CFG_RECYCLE_MODE, 32'd0);
    repeat (9) process_raw(pick_raw());
    cfg_write(CFG_RECYCLE_MODE, 32'd1);
    repeat (4) process_raw(pick_raw());
  endtask

  task automatic test_random_phases();
    int unsigned sel;
    logic [CFG_W-1:0] len;
    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        cfg_write_noisy(CFG_SAMPLE_IS_32BIT, 1);
        cfg_write_noisy(CFG_RAW_PASSTHROUGH, 0);
        cfg_write_noisy(CFG_CHANNEL_COUNT, 31);
        cfg_write_noisy(CFG_BUFFER_LENGTH, '1);
        cfg_write_noisy(CFG_RECYCLE_MODE, 1);
      end else if (p == 1) begin
        cfg_write_noisy(CFG_SAMPLE_IS_32BIT, 0);
        cfg_write_noisy(CFG_RAW_PASSTHROUGH, 0);
        cfg_write_noisy(CFG_CHANNEL_COUNT, 0);
        cfg_write_noisy(CFG_BUFFER_LENGTH, 0);
        cfg_write_noisy(CFG_RECYCLE_MODE, 0);
      end else begin
        sel = $urandom_range(9);
        len = (sel == 0) ? '0 : ((sel == 1) ? CFG_W'($urandom) : $urandom_range(1, 40));
        cfg_write_noisy(CFG_SAMPLE_IS_32BIT, $urandom_range(1));
        cfg_write_noisy(CFG_RAW_PASSTHROUGH, ($urandom_range(9) < 3));
        cfg_write_noisy(CFG_CHANNEL_COUNT, $urandom_range(0, 20));
        cfg_write_noisy(CFG_BUFFER_LENGTH, len);
        cfg_write_noisy(CFG_RECYCLE_MODE, $urandom_range(1));
      end
      // One phase runs with neither side idling.
      calm = (p == 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(99) < 15) begin
          sel = $urandom_range(3);
          load_coef(CH_OUT_W'($urandom), kind_e'(sel), pick_coef(kind_e'(sel)));
        end else begin
          process_raw(pick_raw());
        end
      end
      calm = 1'b0;
    end
  endtask

  initial begin : main
    int waited;
    cfg_wide_sample = 1'b0;
    cfg_passthrough = 1'b0;
    cfg_chan_count = CC_W'(1);
    cfg_buf_len = BUF_W'(1);
    cfg_recycle = 1'b0;
    scan_ch = '0;
    buf_idx = '0;
    sample_total = '0;
    waited = 0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_coefficient_loads();
    test_field_extremes();
    test_count_limits();
    test_completion_wrap();
    test_random_phases();

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    mismatch_count += pending_results.size();
    repeat (30) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
